FILE: rtl/core/atbi_pkg.sv
// ----------------------------------------------------------------------------
// atbi_pkg
// Shared types, constants and arithmetic helpers for the angle table
// bilinear interpolator.
// ----------------------------------------------------------------------------
package atbi_pkg;

    localparam int MAX_POINTS  = 256;
    localparam int PT_W        = $clog2(MAX_POINTS);
    localparam int CNT_W       = PT_W + 1;
    localparam int COEFF_W     = 16;
    localparam int ANGLE_W     = 16;
    localparam int INV_W       = 24;
    localparam int PROD_W      = ANGLE_W + INV_W;
    localparam int IDX_LSB     = 23;
    localparam int FRAC_W      = 16;
    localparam int FRAC_LSB    = 7;
    localparam int IDX_W       = PROD_W - IDX_LSB;
    localparam int W_W         = FRAC_W + 1;
    localparam int MUL_W       = COEFF_W + W_W + 1;
    localparam int ENTRY_W     = 2 * COEFF_W;
    localparam int GRID_AW     = 2 * PT_W;
    localparam int QUEUE_DEPTH = 4;
    localparam int OUT_DEPTH   = 8;

    localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(MAX_POINTS);
    localparam logic [INV_W-1:0] INV_RESET   = INV_W'(46421);

    typedef enum logic
    {
        OP_WRITE,
        OP_LOOKUP
    } atbi_op_t;

    typedef enum logic [1:0]
    {
        SEL_PITCH,
        SEL_YAW,
        SEL_GRID,
        SEL_NONE
    } atbi_sel_t;

    typedef enum logic [1:0]
    {
        REG_LINE_COUNT,
        REG_LINE_INV,
        REG_GRID_COUNT,
        REG_GRID_INV
    } atbi_reg_t;

    typedef struct packed
    {
        logic [CNT_W-1:0] line_count;
        logic [INV_W-1:0] line_inv;
        logic [CNT_W-1:0] grid_count;
        logic [INV_W-1:0] grid_inv;
    } atbi_cfg_t;

    typedef struct packed
    {
        atbi_op_t                   opcode;
        atbi_sel_t                  sel;
        logic [PROD_W-1:0]          prod_p;
        logic [PROD_W-1:0]          prod_y;
        logic [PT_W-1:0]            row;
        logic [PT_W-1:0]            col;
        logic signed [COEFF_W-1:0]  lift;
        logic signed [COEFF_W-1:0]  drag;
    } atbi_item_t;

    typedef struct packed
    {
        logic [PT_W-1:0]   lo;
        logic [PT_W-1:0]   hi;
        logic [FRAC_W-1:0] frac;
        logic              sat;
    } atbi_axis_t;

    typedef struct packed
    {
        logic                       sat;
        logic signed [COEFF_W-1:0]  drag;
        logic signed [COEFF_W-1:0]  lift;
    } atbi_result_t;

    // split a scaled angle into lower point, upper point, fraction and saturation flag
    function automatic atbi_axis_t decode_axis(input logic [PROD_W-1:0] prod,
                                               input logic [CNT_W-1:0] count);
        atbi_axis_t      d;
        logic [CNT_W-1:0] c;
        logic [PT_W-1:0]  last;
        logic [IDX_W-1:0] idx;
        c = count;
        if (count < CNT_W'(2))
        begin
            c = CNT_W'(2);
        end
        else if (count > CNT_W'(MAX_POINTS))
        begin
            c = CNT_W'(MAX_POINTS);
        end
        last   = PT_W'(c - CNT_W'(1));
        idx    = prod[PROD_W-1:IDX_LSB];
        d.frac = prod[FRAC_LSB+FRAC_W-1:FRAC_LSB];
        d.sat  = 1'b0;
        d.lo   = idx[PT_W-1:0];
        if (idx > IDX_W'(last))
        begin
            d.lo   = last;
            d.frac = '0;
            d.sat  = 1'b1;
        end
        d.hi = (d.lo == last) ? '0 : d.lo + PT_W'(1);
        return d;
    endfunction

    function automatic logic [W_W-1:0] inv_weight(input logic [FRAC_W-1:0] f);
        return (W_W'(1) << FRAC_W) - {1'b0, f};
    endfunction

    function automatic logic signed [MUL_W-1:0] wmul(input logic signed [COEFF_W-1:0] a,
                                                      input logic [W_W-1:0] w);
        logic signed [MUL_W-1:0] ae;
        logic signed [MUL_W-1:0] we;
        ae = MUL_W'(a);
        we = $signed({{(MUL_W-W_W){1'b0}}, w});
        return ae * we;
    endfunction

    // round, floor-shift and clamp one blended sum
    function automatic logic signed [COEFF_W-1:0] round_sat(input logic signed [MUL_W-1:0] m0,
                                                             input logic signed [MUL_W-1:0] m1);
        logic signed [MUL_W-1:0]        v;
        logic signed [MUL_W-FRAC_W-1:0] r;
        logic signed [MUL_W-FRAC_W-1:0] cmax;
        logic signed [MUL_W-FRAC_W-1:0] cmin;
        cmax = (MUL_W-FRAC_W)'((1 << (COEFF_W - 1)) - 1);
        cmin = -cmax - (MUL_W-FRAC_W)'(1);
        v    = m0 + m1 + (MUL_W'(1) <<< (FRAC_W - 1));
        r    = v[MUL_W-1:FRAC_W];
        if (r > cmax)
        begin
            r = cmax;
        end
        else if (r < cmin)
        begin
            r = cmin;
        end
        return r[COEFF_W-1:0];
    endfunction

endpackage

FILE: rtl/core/angle_table_bilinear_interp.sv
// ----------------------------------------------------------------------------
// angle_table_bilinear_interp
// Lift/drag coefficient tables over pitch, yaw and a pitch-by-yaw grid,
// with linear and bilinear interpolation of lookups.
//
// Channel  | Dir | Payload
// s_axis   | in  | tuser: opcode, table_select; tdata: angles, entry fields
// m_axis   | out | tuser: index_saturated; tdata: lift_coeff, drag_coeff
// cfg      | in  | cfg_we, cfg_index, cfg_data
//
// One item per cycle sustained while the output is not stalled. A lookup
// result passes through the front scaling multiply, queue, table read, two
// blend levels and result buffer. Writes reach the table stores at the edge
// they leave the queue and give no result. Output stalls fill an 8-entry
// result buffer, then the queue, then input ready drops. Reset clears
// control state only; table contents are unknown until written.
// ----------------------------------------------------------------------------
module angle_table_bilinear_interp (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] opcode, [2:1] table_select
    input  logic [2:0]  s_axis_tuser,
    // [15:0] pitch_angle, [31:16] yaw_angle, [39:32] entry_row,
    // [47:40] entry_col, [63:48] entry_lift, [79:64] entry_drag
    input  logic [79:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] index_saturated
    output logic        m_axis_tuser,
    // [15:0] lift_coeff, [31:16] drag_coeff
    output logic [31:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    import atbi_pkg::*;

    atbi_cfg_t    cfg_reg;
    atbi_cfg_t    cfg_next;
    logic         f_valid;
    logic         f_ready;
    atbi_item_t   f_item;
    logic         q_valid;
    logic         q_pop;
    atbi_item_t   q_item;
    atbi_result_t result;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (atbi_reg_t'(cfg_index))
                REG_LINE_COUNT: cfg_next.line_count = cfg_data[CNT_W-1:0];
                REG_LINE_INV:   cfg_next.line_inv   = cfg_data[INV_W-1:0];
                REG_GRID_COUNT: cfg_next.grid_count = cfg_data[CNT_W-1:0];
                REG_GRID_INV:   cfg_next.grid_inv   = cfg_data[INV_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.line_count <= COUNT_RESET;
            cfg_reg.line_inv   <= INV_RESET;
            cfg_reg.grid_count <= COUNT_RESET;
            cfg_reg.grid_inv   <= INV_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    atbi_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_user    (s_axis_tuser),
        .in_data    (s_axis_tdata),
        .item_valid (f_valid),
        .item_ready (f_ready),
        .item       (f_item)
    );

    atbi_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_item  (f_item),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_item   (q_item)
    );

    atbi_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_item     (q_item),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (result)
    );

    assign m_axis_tuser = result.sat;
    assign m_axis_tdata = {result.drag, result.lift};

endmodule

FILE: rtl/core/atbi_ram.sv
// ----------------------------------------------------------------------------
// atbi_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module atbi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/atbi_front.sv
// ----------------------------------------------------------------------------
// atbi_front
// Input stage: unpacks an item and scales its angles by the inverse step.
// ----------------------------------------------------------------------------
module atbi_front (
    input  logic                clk,
    input  logic                rst_n,
    input  atbi_pkg::atbi_cfg_t cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          in_user,
    input  logic [79:0]         in_data,
    output logic                item_valid,
    input  logic                item_ready,
    output atbi_pkg::atbi_item_t item
);
    import atbi_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    atbi_item_t item_reg;
    atbi_item_t item_next;
    logic [INV_W-1:0] inv;
    logic       take;

    assign in_ready = !valid_reg || item_ready;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        item_next.opcode = atbi_op_t'(in_user[0]);
        item_next.sel    = atbi_sel_t'(in_user[2:1]);
        inv = (item_next.sel == SEL_GRID) ? cfg.grid_inv : cfg.line_inv;
        item_next.prod_p = PROD_W'(in_data[15:0]) * PROD_W'(inv);
        item_next.prod_y = PROD_W'(in_data[31:16]) * PROD_W'(inv);
        item_next.row    = in_data[39:32];
        item_next.col    = in_data[47:40];
        item_next.lift   = in_data[63:48];
        item_next.drag   = in_data[79:64];
        valid_next = take || (valid_reg && !item_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: rtl/core/atbi_queue.sv
// ----------------------------------------------------------------------------
// atbi_queue
// Short item queue between the front and the back.
// ----------------------------------------------------------------------------
module atbi_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  atbi_pkg::atbi_item_t push_item,
    output logic                 pop_valid,
    input  logic                 pop,
    output atbi_pkg::atbi_item_t pop_item
);
    import atbi_pkg::*;

    localparam int QA_W = $clog2(QUEUE_DEPTH);
    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

    atbi_item_t        slot [QUEUE_DEPTH];
    logic [QA_W-1:0]   wr_ptr_reg;
    logic [QA_W-1:0]   wr_ptr_next;
    logic [QA_W-1:0]   rd_ptr_reg;
    logic [QA_W-1:0]   rd_ptr_next;
    logic [QC_W-1:0]   count_reg;
    logic [QC_W-1:0]   count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = count_reg != QC_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;
    assign pop_item   = slot[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QA_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QA_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QC_W'(do_push) - QC_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: rtl/core/atbi_back.sv
// ----------------------------------------------------------------------------
// atbi_back
// Table stores, blend pipeline and result buffer.
// ----------------------------------------------------------------------------
module atbi_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  atbi_pkg::atbi_cfg_t  cfg,
    input  logic                 q_valid,
    output logic                 q_pop,
    input  atbi_pkg::atbi_item_t q_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output atbi_pkg::atbi_result_t out_result
);
    import atbi_pkg::*;

    localparam int OA_W = $clog2(OUT_DEPTH);
    localparam int OC_W = $clog2(OUT_DEPTH + 1);

    // issue and decode
    logic       is_res;
    logic       is_write;
    atbi_axis_t dl;
    atbi_axis_t dp;
    atbi_axis_t dy;
    logic [OC_W-1:0] credit_reg;
    logic [OC_W-1:0] credit_next;
    logic       out_take;
    logic [ENTRY_W-1:0] wdata;

    assign is_res   = (q_item.opcode == OP_LOOKUP) && (q_item.sel != SEL_NONE);
    assign is_write = q_item.opcode == OP_WRITE;
    assign q_pop    = q_valid && (!is_res || credit_reg != OC_W'(OUT_DEPTH));
    assign wdata    = {q_item.drag, q_item.lift};

    always_comb
    begin
        dl = decode_axis((q_item.sel == SEL_PITCH) ? q_item.prod_p : q_item.prod_y,
                         cfg.line_count);
        dp = decode_axis(q_item.prod_p, cfg.grid_count);
        dy = decode_axis(q_item.prod_y, cfg.grid_count);
    end

    // duplicated stores give each neighbor its own read port
    logic we_p;
    logic we_y;
    logic we_g;
    logic [ENTRY_W-1:0] rd_pl0;
    logic [ENTRY_W-1:0] rd_pl1;
    logic [ENTRY_W-1:0] rd_yl0;
    logic [ENTRY_W-1:0] rd_yl1;
    logic [ENTRY_W-1:0] rd_ga;
    logic [ENTRY_W-1:0] rd_gb;
    logic [ENTRY_W-1:0] rd_gc;
    logic [ENTRY_W-1:0] rd_gd;

    assign we_p = q_pop && is_write && (q_item.sel == SEL_PITCH);
    assign we_y = q_pop && is_write && (q_item.sel == SEL_YAW);
    assign we_g = q_pop && is_write && (q_item.sel == SEL_GRID);

    atbi_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_POINTS)) u_pl0 (
        .clk(clk), .wr_en(we_p), .wr_addr(q_item.row), .wr_data(wdata),
        .rd_addr(dl.lo), .rd_data(rd_pl0));
    atbi_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_POINTS)) u_pl1 (
        .clk(clk), .wr_en(we_p), .wr_addr(q_item.row), .wr_data(wdata),
        .rd_addr(dl.hi), .rd_data(rd_pl1));
    atbi_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_POINTS)) u_yl0 (
        .clk(clk), .wr_en(we_y), .wr_addr(q_item.row), .wr_data(wdata),
        .rd_addr(dl.lo), .rd_data(rd_yl0));
    atbi_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_POINTS)) u_yl1 (
        .clk(clk), .wr_en(we_y), .wr_addr(q_item.row), .wr_data(wdata),
        .rd_addr(dl.hi), .rd_data(rd_yl1));
    atbi_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_POINTS * MAX_POINTS)) u_ga (
        .clk(clk), .wr_en(we_g), .wr_addr({q_item.row, q_item.col}), .wr_data(wdata),
        .rd_addr({dp.lo, dy.lo}), .rd_data(rd_ga));
    atbi_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_POINTS * MAX_POINTS)) u_gb (
        .clk(clk), .wr_en(we_g), .wr_addr({q_item.row, q_item.col}), .wr_data(wdata),
        .rd_addr({dp.lo, dy.hi}), .rd_data(rd_gb));
    atbi_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_POINTS * MAX_POINTS)) u_gc (
        .clk(clk), .wr_en(we_g), .wr_addr({q_item.row, q_item.col}), .wr_data(wdata),
        .rd_addr({dp.hi, dy.lo}), .rd_data(rd_gc));
    atbi_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_POINTS * MAX_POINTS)) u_gd (
        .clk(clk), .wr_en(we_g), .wr_addr({q_item.row, q_item.col}), .wr_data(wdata),
        .rd_addr({dp.hi, dy.hi}), .rd_data(rd_gd));

    // stage 1: read data returns
    logic              s1_valid_reg;
    atbi_sel_t         s1_sel_reg;
    logic [FRAC_W-1:0] s1_f1_reg;
    logic [FRAC_W-1:0] s1_f2_reg;
    logic              s1_sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= q_pop && is_res;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_sel_reg <= q_item.sel;
        s1_f1_reg  <= (q_item.sel == SEL_GRID) ? dy.frac : dl.frac;
        s1_f2_reg  <= dp.frac;
        s1_sat_reg <= (q_item.sel == SEL_GRID) ? (dp.sat || dy.sat) : dl.sat;
    end

    // stage 2: first-level products, [0]=lift, [1]=drag
    logic [ENTRY_W-1:0] ea;
    logic [ENTRY_W-1:0] eb;
    logic [W_W-1:0]     w1i;
    logic [W_W-1:0]     w1;
    logic              s2_valid_reg;
    logic              s2_grid_reg;
    logic [FRAC_W-1:0] s2_f2_reg;
    logic              s2_sat_reg;
    logic signed [MUL_W-1:0] s2_m_reg [2][4];

    always_comb
    begin
        ea  = (s1_sel_reg == SEL_GRID) ? rd_ga :
              (s1_sel_reg == SEL_PITCH) ? rd_pl0 : rd_yl0;
        eb  = (s1_sel_reg == SEL_GRID) ? rd_gb :
              (s1_sel_reg == SEL_PITCH) ? rd_pl1 : rd_yl1;
        w1i = inv_weight(s1_f1_reg);
        w1  = W_W'(s1_f1_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_grid_reg <= s1_sel_reg == SEL_GRID;
        s2_f2_reg   <= s1_f2_reg;
        s2_sat_reg  <= s1_sat_reg;
        for (int k = 0; k < 2; k++)
        begin
            s2_m_reg[k][0] <= wmul(ea[k*COEFF_W +: COEFF_W], w1i);
            s2_m_reg[k][1] <= wmul(eb[k*COEFF_W +: COEFF_W], w1);
            s2_m_reg[k][2] <= wmul(rd_gc[k*COEFF_W +: COEFF_W], w1i);
            s2_m_reg[k][3] <= wmul(rd_gd[k*COEFF_W +: COEFF_W], w1);
        end
    end

    // stage 3: first-level round and clamp
    logic              s3_valid_reg;
    logic              s3_grid_reg;
    logic [FRAC_W-1:0] s3_f2_reg;
    logic              s3_sat_reg;
    logic signed [COEFF_W-1:0] s3_r0_reg [2];
    logic signed [COEFF_W-1:0] s3_r1_reg [2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_grid_reg <= s2_grid_reg;
        s3_f2_reg   <= s2_f2_reg;
        s3_sat_reg  <= s2_sat_reg;
        for (int k = 0; k < 2; k++)
        begin
            s3_r0_reg[k] <= round_sat(s2_m_reg[k][0], s2_m_reg[k][1]);
            s3_r1_reg[k] <= round_sat(s2_m_reg[k][2], s2_m_reg[k][3]);
        end
    end

    // stage 4: pitch-axis products for the grid
    logic              s4_valid_reg;
    logic              s4_grid_reg;
    logic              s4_sat_reg;
    logic signed [COEFF_W-1:0] s4_r0_reg [2];
    logic signed [MUL_W-1:0]   s4_n_reg [2][2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s4_grid_reg <= s3_grid_reg;
        s4_sat_reg  <= s3_sat_reg;
        for (int k = 0; k < 2; k++)
        begin
            s4_r0_reg[k]   <= s3_r0_reg[k];
            s4_n_reg[k][0] <= wmul(s3_r0_reg[k], inv_weight(s3_f2_reg));
            s4_n_reg[k][1] <= wmul(s3_r1_reg[k], W_W'(s3_f2_reg));
        end
    end

    // stage 5: final result into the output buffer
    atbi_result_t res;

    always_comb
    begin
        res.sat  = s4_sat_reg;
        res.lift = s4_grid_reg ? round_sat(s4_n_reg[0][0], s4_n_reg[0][1]) : s4_r0_reg[0];
        res.drag = s4_grid_reg ? round_sat(s4_n_reg[1][0], s4_n_reg[1][1]) : s4_r0_reg[1];
    end

    atbi_result_t    obuf [OUT_DEPTH];
    logic [OA_W-1:0] owr_reg;
    logic [OA_W-1:0] owr_next;
    logic [OA_W-1:0] ord_reg;
    logic [OA_W-1:0] ord_next;
    logic [OC_W-1:0] ocnt_reg;
    logic [OC_W-1:0] ocnt_next;

    assign out_valid  = ocnt_reg != '0;
    assign out_take   = out_valid && out_ready;
    assign out_result = obuf[ord_reg];

    // credits cover results in flight plus those buffered
    always_comb
    begin
        owr_next    = s4_valid_reg ? owr_reg + OA_W'(1) : owr_reg;
        ord_next    = out_take ? ord_reg + OA_W'(1) : ord_reg;
        ocnt_next   = ocnt_reg + OC_W'(s4_valid_reg) - OC_W'(out_take);
        credit_next = credit_reg + OC_W'(q_pop && is_res) - OC_W'(out_take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owr_reg    <= '0;
            ord_reg    <= '0;
            ocnt_reg   <= '0;
            credit_reg <= '0;
        end
        else
        begin
            owr_reg    <= owr_next;
            ord_reg    <= ord_next;
            ocnt_reg   <= ocnt_next;
            credit_reg <= credit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s4_valid_reg)
        begin
            obuf[owr_reg] <= res;
        end
    end

endmodule
